// ===== rtl/e321_pkg.sv =====
// Package for the Euler 3-2-1 frame rotation block: widths, CORDIC constants and helpers.
package e321_pkg;

    localparam int VEC_WIDTH     = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    // CORDIC datapath widths. x and y stay within about +-1.65 in Q30, z within +-2^31.
    localparam int CW = 33;
    localparam int ZW = 34;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
    localparam logic signed [CW:0]   Q30_ONE     = 34'sh040000000;

    function automatic zval_t atan_lut(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
                3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
                9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
                12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
                15: v = 32'h0000517C;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
                18: v = 32'h00000A2F;  19: v = 32'h00000517;  20: v = 32'h0000028B;
                21: v = 32'h00000145;  22: v = 32'h000000A2;  23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_lut = zval_t'({2'b00, v});
        end
    endfunction

    // Q30 by Q30 product rounded back to Q30 (add half, floor shift).
    function automatic logic signed [CW:0] mul_q30(input logic signed [CW:0] a,
                                                   input logic signed [CW:0] b);
        logic signed [2*CW+1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            mul_q30 = p[CW+30:30];
        end
    endfunction

    // One sine/cosine lane: the three angles travel side by side.
    typedef struct packed {
        cval_t [2:0] x;
        cval_t [2:0] y;
        zval_t [2:0] z;
        logic  [2:0] flip;
    } lane_t;

    typedef struct packed {
        logic                        req_type;
        logic signed [VEC_WIDTH-1:0] vx;
        logic signed [VEC_WIDTH-1:0] vy;
        logic signed [VEC_WIDTH-1:0] vz;
    } side_t;

endpackage

// ===== rtl/e321_cordic_cell.sv =====
// One CORDIC micro-rotation cell for three angles, with its side data and valid bit.
module e321_cordic_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [4:0]    shift,
    input  e321_pkg::zval_t atan_val,
    input  logic          advance,
    input  logic          valid_in,
    input  e321_pkg::lane_t lane_in,
    input  e321_pkg::side_t side_in,
    output logic          valid_out,
    output e321_pkg::lane_t lane_out,
    output e321_pkg::side_t side_out
);
    import e321_pkg::*;

    logic  valid_reg;
    lane_t lane_reg, lane_next;
    side_t side_reg;

    always_comb
    begin
        lane_next = lane_in;
        for (int k = 0; k < 3; k++)
        begin
            if (!lane_in.z[k][ZW-1])
            begin
                lane_next.x[k] = lane_in.x[k] - (lane_in.y[k] >>> shift);
                lane_next.y[k] = lane_in.y[k] + (lane_in.x[k] >>> shift);
                lane_next.z[k] = lane_in.z[k] - atan_val;
            end
            else
            begin
                lane_next.x[k] = lane_in.x[k] + (lane_in.y[k] >>> shift);
                lane_next.y[k] = lane_in.y[k] - (lane_in.x[k] >>> shift);
                lane_next.z[k] = lane_in.z[k] + atan_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;
    assign side_out  = side_reg;
endmodule

// ===== rtl/e321_matrix.sv =====
// Back end: builds the direction cosine matrix, multiplies the vector, rounds and saturates.
module e321_matrix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          valid_in,
    input  e321_pkg::lane_t lane_in,
    input  e321_pkg::side_t side_in,
    output logic          valid_out,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] rx,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] ry,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] rz,
    output logic          clip
);
    import e321_pkg::*;

    localparam int MW  = CW + 1;
    localparam int PW  = MW + 1 + VEC_WIDTH;
    localparam int AW  = PW + 2;

    typedef logic signed [MW-1:0] m_t;

    // Stage A: fold the quadrant sign back; sine/cosine of roll, pitch, yaw.
    logic [3:0] v_reg;
    m_t sr_a_reg, cr_a_reg, sp_a_reg, cp_a_reg, sy_a_reg, cy_a_reg;
    side_t s_a_reg, s_b_reg, s_c_reg, s_d_reg;
    m_t srsp_b_reg, crsp_b_reg, sp_b_reg, sr_b_reg, cr_b_reg, sy_b_reg, cy_b_reg, cp_b_reg;
    m_t r_c_reg [3][3];
    logic signed [PW-1:0] p_d_reg [3][3];

    function automatic m_t unfold(input cval_t v, input logic f);
        unfold = f ? -m_t'(v) : m_t'(v);
    endfunction

    function automatic m_t clamp(input m_t v);
        if (v > Q30_ONE) clamp = Q30_ONE;
        else if (v < -Q30_ONE) clamp = -Q30_ONE;
        else clamp = v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sr_a_reg <= unfold(lane_in.y[0], lane_in.flip[0]);
            cr_a_reg <= unfold(lane_in.x[0], lane_in.flip[0]);
            sp_a_reg <= unfold(lane_in.y[1], lane_in.flip[1]);
            cp_a_reg <= unfold(lane_in.x[1], lane_in.flip[1]);
            sy_a_reg <= unfold(lane_in.y[2], lane_in.flip[2]);
            cy_a_reg <= unfold(lane_in.x[2], lane_in.flip[2]);
            s_a_reg  <= side_in;

            // Stage B: shared partial products.
            srsp_b_reg <= mul_q30(sr_a_reg, sp_a_reg);
            crsp_b_reg <= mul_q30(cr_a_reg, sp_a_reg);
            sp_b_reg <= sp_a_reg; sr_b_reg <= sr_a_reg; cr_b_reg <= cr_a_reg;
            sy_b_reg <= sy_a_reg; cy_b_reg <= cy_a_reg; cp_b_reg <= cp_a_reg;
            s_b_reg  <= s_a_reg;

            // Stage C: matrix entries, clamped, transposed when asked.
            s_c_reg <= s_b_reg;
            begin
                m_t r [3][3];
                r[0][0] = mul_q30(cp_b_reg, cy_b_reg);
                r[0][1] = mul_q30(srsp_b_reg, cy_b_reg) - mul_q30(cr_b_reg, sy_b_reg);
                r[0][2] = mul_q30(crsp_b_reg, cy_b_reg) + mul_q30(sr_b_reg, sy_b_reg);
                r[1][0] = mul_q30(cp_b_reg, sy_b_reg);
                r[1][1] = mul_q30(srsp_b_reg, sy_b_reg) + mul_q30(cr_b_reg, cy_b_reg);
                r[1][2] = mul_q30(crsp_b_reg, sy_b_reg) - mul_q30(sr_b_reg, cy_b_reg);
                r[2][0] = -sp_b_reg;
                r[2][1] = mul_q30(sr_b_reg, cp_b_reg);
                r[2][2] = mul_q30(cr_b_reg, cp_b_reg);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        r_c_reg[i][j] <= clamp(s_b_reg.req_type ? r[j][i] : r[i][j]);
            end

            // Stage D: nine entry-by-component products.
            s_d_reg <= s_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                p_d_reg[i][0] <= PW'(r_c_reg[i][0] * s_c_reg.vx);
                p_d_reg[i][1] <= PW'(r_c_reg[i][1] * s_c_reg.vy);
                p_d_reg[i][2] <= PW'(r_c_reg[i][2] * s_c_reg.vz);
            end
        end
    end

    // Stage E: sum, round and saturate, into the output register.
    logic signed [VEC_WIDTH-1:0] o_next [3];
    logic [2:0] c_next;
    logic signed [VEC_WIDTH-1:0] ox_reg, oy_reg, oz_reg;
    logic clip_reg, valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [AW-1:0] acc;
            logic signed [AW-31:0] q;
            acc = AW'(p_d_reg[i][0]) + AW'(p_d_reg[i][1]) + AW'(p_d_reg[i][2])
                  + (AW'(1) <<< 29);
            q = acc[AW-1:30];
            c_next[i] = 1'b0;
            o_next[i] = q[VEC_WIDTH-1:0];
            if (q > (AW-30)'((1 <<< (VEC_WIDTH-1)) - 1))
            begin
                o_next[i] = {1'b0, {(VEC_WIDTH-1){1'b1}}};
                c_next[i] = 1'b1;
            end
            else if (q < -(AW-30)'(1 <<< (VEC_WIDTH-1)))
            begin
                o_next[i] = {1'b1, {(VEC_WIDTH-1){1'b0}}};
                c_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= v_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ox_reg <= o_next[0];
            oy_reg <= o_next[1];
            oz_reg <= o_next[2];
            clip_reg <= |c_next;
        end
    end

    assign valid_out = valid_reg;
    assign rx = ox_reg;
    assign ry = oy_reg;
    assign rz = oz_reg;
    assign clip = clip_reg;
endmodule

// ===== rtl/euler_321_frame_rotation.sv =====
// Top level of the Euler 3-2-1 frame rotation pipeline.
//
//   channel | handshake         | word contents
//   --------+-------------------+-----------------------------------------------
//   in      | in_valid/in_stall | req_type, vec_x, vec_y, vec_z, roll, pitch, yaw
//   out     | out_valid/out_stall | rot_x, rot_y, rot_z, clipped
//
// One word is accepted every cycle while the output does not stall. The path
// holds one entry register, one CORDIC cell per stage, and five back-end stages
// that build the matrix, multiply and round. The whole pipeline advances as one
// when the output register is empty or being taken, so a stall on the output
// holds every stage in place. Reset clears only the valid bits.
module euler_321_frame_rotation (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic req_type,
    input  logic signed [e321_pkg::VEC_WIDTH-1:0]   vec_x,
    input  logic signed [e321_pkg::VEC_WIDTH-1:0]   vec_y,
    input  logic signed [e321_pkg::VEC_WIDTH-1:0]   vec_z,
    input  logic signed [e321_pkg::ANGLE_WIDTH-1:0] roll,
    input  logic signed [e321_pkg::ANGLE_WIDTH-1:0] pitch,
    input  logic signed [e321_pkg::ANGLE_WIDTH-1:0] yaw,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] rot_x,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] rot_y,
    output logic signed [e321_pkg::VEC_WIDTH-1:0] rot_z,
    output logic clipped
);
    import e321_pkg::*;

    // The pipeline moves whenever the output word is absent or being taken.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Entry: place each angle in a 32-bit phase and fold it into +-pi/2.
    lane_t lane0_next;
    side_t side0_next;
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    assign ang[0] = roll;
    assign ang[1] = pitch;
    assign ang[2] = yaw;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [31:0] ph;
            ph = {ang[k], {(32-ANGLE_WIDTH){1'b0}}};
            lane0_next.flip[k] = ph[31] ^ ph[30];
            if (lane0_next.flip[k])
                ph[31] = ~ph[31];
            lane0_next.z[k] = zval_t'(signed'(ph));
            lane0_next.x[k] = CORDIC_GAIN;
            lane0_next.y[k] = '0;
        end
        side0_next.req_type = req_type;
        side0_next.vx = vec_x;
        side0_next.vy = vec_y;
        side0_next.vz = vec_z;
    end

    logic  valid0_reg;
    lane_t lane0_reg;
    side_t side0_reg;

    logic  v_q [NUM_STAGES+1];
    lane_t l_q [NUM_STAGES+1];
    side_t s_q [NUM_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else if (advance)
            valid0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lane0_reg <= lane0_next;
            side0_reg <= side0_next;
        end
    end

    assign v_q[0] = valid0_reg;
    assign l_q[0] = lane0_reg;
    assign s_q[0] = side0_reg;

    // Chain of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_cell
        e321_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (5'(g)),
            .atan_val  (atan_lut(g)),
            .advance   (advance),
            .valid_in  (v_q[g]),
            .lane_in   (l_q[g]),
            .side_in   (s_q[g]),
            .valid_out (v_q[g+1]),
            .lane_out  (l_q[g+1]),
            .side_out  (s_q[g+1])
        );
    end

    e321_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (v_q[NUM_STAGES]),
        .lane_in   (l_q[NUM_STAGES]),
        .side_in   (s_q[NUM_STAGES]),
        .valid_out (out_valid),
        .rx        (rot_x),
        .ry        (rot_y),
        .rz        (rot_z),
        .clip      (clipped)
    );
endmodule
